/* hdl/acw_pkg.sv */
// Shared types and constants for the AIMD congestion window block.
// Used by acw_ctrl, acw_datapath, acw_recip and the top level.
`timescale 1ns / 1ps

package acw_pkg;

   // Field widths fixed by the stream format
   localparam int WIN_BITS        = 32;
   localparam int SEQ_BITS        = 32;
   localparam int FLOW_FIELD_BITS = 16;
   localparam int TICK_FIELD_BITS = 32;
   localparam int COUNT_BITS      = 32;

   // Bus widths: request tdata is seq, flow, sent tick, received tick, sent count
   localparam int REQ_TDATA_BITS = 144;
   localparam int REQ_TUSER_BITS = 2;
   localparam int RSP_TDATA_BITS = 40;

   // Defaults for the top-level parameters
   localparam int FRAC_BITS_DEF = 16;
   localparam int TICK_BITS_DEF = 32;
   localparam int FLOW_BITS_DEF = 16;

   // Request kinds carried in tuser
   localparam logic ACTION_ACK   = 1'b0;
   localparam logic ACTION_RESET = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;       // capture the request transaction
      logic update;     // apply the ack or flow-reset update
      logic start_div;  // start the reciprocal of the window
      logic add_recip;  // add the reciprocal to the window
      logic publish;    // load the result register
   } acw_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic needs_div;  // current item grows the window by its reciprocal
      logic div_done;   // reciprocal ready
   } acw_status_type;

endpackage

/* hdl/acw_recip.sv */
// Bit-serial reciprocal of the window: quotient = 2^(2*FRAC_BITS) / divisor.
// One quotient bit per cycle, FRAC_BITS+1 quotient bits in all. Depends on acw_pkg.
`timescale 1ns / 1ps

module acw_recip
   import acw_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIN_BITS-1:0]  divisor,
   output logic                 done,
   output logic [FRAC_BITS:0]   quotient
);

   localparam int REC_BITS = FRAC_BITS + 1;
   localparam int CNT_BITS = $clog2(REC_BITS + 1);

   logic [WIN_BITS-1:0] div_ff;
   logic [WIN_BITS-1:0] rem_ff, rem_in;
   logic [REC_BITS-1:0] q_ff, q_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [WIN_BITS:0]   shifted;
   logic [WIN_BITS:0]   diff;
   logic                ge;

   // One restoring step; the dividend bits below the top are all zero
   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, div_ff};
   assign ge      = shifted >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = WIN_BITS'(1) << (FRAC_BITS - 1);
         q_in    = '0;
         cnt_in  = CNT_BITS'(REC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[WIN_BITS-1:0] : shifted[WIN_BITS-1:0];
         q_in   = {q_ff[REC_BITS-2:0], ge};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

`ifndef SYNTHESIS
   // Partial remainder always below the divisor
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> rem_ff < div_ff)
      else $error("acw_recip: partial remainder not below divisor");
   // Window is at least 1.0, so the reciprocal never exceeds 1.0
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (q_ff[FRAC_BITS] == 1'b0) || (q_ff[FRAC_BITS-1:0] == '0))
      else $error("acw_recip: reciprocal above 1.0");
`endif

endmodule

/* hdl/acw_datapath.sv */
// Datapath of the congestion window: request capture, flow state, window
// update, reciprocal unit and result register. Depends on acw_pkg, acw_recip.
`timescale 1ns / 1ps

module acw_datapath
   import acw_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int TICK_BITS = TICK_BITS_DEF,
   parameter int FLOW_BITS = FLOW_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  acw_cmd_type                cmd,
   output acw_status_type             status,
   input  logic [REQ_TDATA_BITS-1:0]  req_tdata,
   input  logic [REQ_TUSER_BITS-1:0]  req_tuser,
   output logic [RSP_TDATA_BITS-1:0]  rsp_tdata
);

   localparam int TW = (TICK_BITS < TICK_FIELD_BITS) ? TICK_BITS : TICK_FIELD_BITS;
   localparam int FW = (FLOW_BITS > FLOW_FIELD_BITS) ? FLOW_BITS : FLOW_FIELD_BITS;
   localparam int MS_BITS = SEQ_BITS + FRAC_BITS + 1;
   localparam int RSP_PAD = RSP_TDATA_BITS - WIN_BITS - 3;
   localparam logic [WIN_BITS-1:0] WIN_ONE = WIN_BITS'(1) << FRAC_BITS;

   // Captured request
   logic                  act_ff;
   logic                  first_ff;
   logic [SEQ_BITS-1:0]   seq_ff;
   logic [FLOW_BITS-1:0]  flow_ff;
   logic [TW-1:0]         tsent_ff;
   logic [TW-1:0]         trecv_ff;
   logic [COUNT_BITS-1:0] sent_ff;

   // Flow state
   logic [WIN_BITS-1:0]   win_ff;
   logic                  ss_ff;
   logic [SEQ_BITS-1:0]   ne_ff;
   logic [FLOW_BITS-1:0]  cur_flow_ff;
   logic [TW:0]           llt_ff;
   logic [TW:0]           rtt_ff;
   logic                  bloss_ff;

   // Result register
   logic [WIN_BITS-1:0]   rsp_win_ff;
   logic                  rsp_ss_ff;
   logic                  rsp_loss_ff;
   logic                  rsp_may_ff;

   logic [FW-1:0]         flow_ext;
   logic                  loss;
   logic [SEQ_BITS:0]     seq_inc;
   logic                  ne_grow;
   logic [SEQ_BITS-1:0]   ne_next;
   logic                  flow_match;
   logic signed [TW+1:0]  llt_x, rtt_x, recv_x, thresh;
   logic                  late;
   logic signed [TW:0]    rtt_new;
   logic [WIN_BITS-1:0]   win_half, win_halved;
   logic [WIN_BITS:0]     win_plus_one, win_plus_rec;
   logic [FLOW_BITS-1:0]  flow_inc;
   logic [FRAC_BITS:0]    recip_q;
   logic                  recip_done;
   logic [MS_BITS-1:0]    sent_scaled, limit_scaled;

   assign flow_ext = FW'(req_tdata[47:32]);

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_tuser[0];
         first_ff <= req_tuser[1];
         seq_ff   <= req_tdata[31:0];
         flow_ff  <= flow_ext[FLOW_BITS-1:0];
         tsent_ff <= req_tdata[48 +: TW];
         trecv_ff <= req_tdata[80 +: TW];
         sent_ff  <= req_tdata[143:112];
      end
   end

   // Loss and sequence tracking
   assign loss       = (bloss_ff && !first_ff) || (seq_ff > ne_ff);
   assign seq_inc    = {1'b0, seq_ff} + (SEQ_BITS + 1)'(1);
   assign ne_grow    = seq_inc > {1'b0, ne_ff};
   assign ne_next    = seq_inc[SEQ_BITS] ? '1 : seq_inc[SEQ_BITS-1:0];
   assign flow_match = flow_ff == cur_flow_ff;

   // At most one halving per measured RTT
   assign llt_x   = {llt_ff[TW], llt_ff};
   assign rtt_x   = {rtt_ff[TW], rtt_ff};
   assign recv_x  = {2'b00, trecv_ff};
   assign thresh  = llt_x + rtt_x;
   assign late    = recv_x > thresh;
   assign rtt_new = $signed({1'b0, trecv_ff}) - $signed({1'b0, tsent_ff});

   // Window candidates
   assign win_half     = win_ff >> 1;
   assign win_halved   = (win_half < WIN_ONE) ? WIN_ONE : win_half;
   assign win_plus_one = {1'b0, win_ff} + {1'b0, WIN_ONE};
   assign win_plus_rec = {1'b0, win_ff} + (WIN_BITS + 1)'(recip_q);

   // Flow id wraps past the top to 1
   always_comb begin
      flow_inc = cur_flow_ff + FLOW_BITS'(1);
      if (flow_inc == '0) begin
         flow_inc = FLOW_BITS'(1);
      end
   end

   acw_recip #(
      .FRAC_BITS (FRAC_BITS)
   ) u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .divisor  (win_ff),
      .done     (recip_done),
      .quotient (recip_q)
   );

   assign status.needs_div = (act_ff == ACTION_ACK) && flow_match && !loss && !ss_ff;
   assign status.div_done  = recip_done;

   // Flow state update
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff      <= WIN_ONE;
         ss_ff       <= 1'b1;
         ne_ff       <= '0;
         cur_flow_ff <= '0;
         llt_ff      <= '1;
         rtt_ff      <= '1;
         bloss_ff    <= 1'b0;
      end else if (cmd.update) begin
         if (act_ff == ACTION_RESET) begin
            win_ff      <= WIN_ONE;
            ss_ff       <= 1'b1;
            cur_flow_ff <= flow_inc;
            ne_ff       <= sent_ff;
         end else begin
            bloss_ff <= loss;
            if (ne_grow) begin
               ne_ff <= ne_next;
            end
            if (flow_match) begin
               if (loss) begin
                  ss_ff <= 1'b0;
                  if (late) begin
                     win_ff <= win_halved;
                     llt_ff <= {1'b0, trecv_ff};
                     rtt_ff <= rtt_new;
                  end
               end else if (ss_ff) begin
                  win_ff <= win_plus_one[WIN_BITS] ? '1 : win_plus_one[WIN_BITS-1:0];
               end
            end
         end
      end else if (cmd.add_recip) begin
         win_ff <= win_plus_rec[WIN_BITS] ? '1 : win_plus_rec[WIN_BITS-1:0];
      end
   end

   // Send permission: sent < next expected + window, in window units
   assign sent_scaled  = {1'b0, sent_ff, {FRAC_BITS{1'b0}}};
   assign limit_scaled = {1'b0, ne_ff, {FRAC_BITS{1'b0}}} + MS_BITS'(win_ff);

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_win_ff  <= win_ff;
         rsp_ss_ff   <= ss_ff;
         rsp_loss_ff <= bloss_ff;
         rsp_may_ff  <= sent_scaled < limit_scaled;
      end
   end

   assign rsp_tdata = {{RSP_PAD{1'b0}}, rsp_may_ff, rsp_loss_ff, rsp_ss_ff, rsp_win_ff};

`ifndef SYNTHESIS
   // Window never drops below 1.0
   assert property (@(posedge clock) disable iff (reset) win_ff >= WIN_ONE)
      else $error("acw_datapath: window below 1.0");
   // A flow reset always lands on a nonzero flow id
   assert property (@(posedge clock) disable iff (reset)
      (cmd.update && act_ff == ACTION_RESET) |=> cur_flow_ff != '0)
      else $error("acw_datapath: flow id zero after flow reset");
`endif

endmodule

/* hdl/acw_ctrl.sv */
// Controller for the congestion window: sequences capture, update,
// reciprocal and result hand-off. Depends on acw_pkg.
`timescale 1ns / 1ps

module acw_ctrl
   import acw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output acw_cmd_type    cmd,
   input  acw_status_type status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      tready_ff, tready_in;
   logic      out_valid_ff, out_valid_in;
   logic      slot_free;

   // Result register can take a new result
   assign slot_free = !out_valid_ff || rsp_tready;

   // Commands
   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == S_IDLE) && tready_ff && req_tvalid;
      cmd.update    = state_ff == S_EVAL;
      cmd.start_div = (state_ff == S_EVAL) && status.needs_div;
      cmd.add_recip = (state_ff == S_DIV) && status.div_done;
      cmd.publish   = (state_ff == S_DONE) && slot_free;
   end

   // Next state
   always_comb begin
      state_in     = state_ff;
      tready_in    = tready_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) begin
               state_in  = S_EVAL;
               tready_in = 1'b0;
            end
         end
         S_EVAL: begin
            state_in = status.needs_div ? S_DIV : S_DONE;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in     = S_IDLE;
               tready_in    = 1'b1;
               out_valid_in = 1'b1;
            end
         end
         default: begin
            state_in  = S_IDLE;
            tready_in = 1'b1;
         end
      endcase
   end

   // State and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tready_ff    <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tready_ff    <= tready_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_tready = tready_ff;
   assign rsp_tvalid = out_valid_ff;

endmodule

/* hdl/aimd_congestion_window_top.sv */
// Top level of the AIMD congestion window: controller plus datapath.
// Depends on acw_pkg, acw_ctrl, acw_datapath (which holds acw_recip).
`timescale 1ns / 1ps

// Sender-side AIMD congestion window with slow start. Each request transaction
// is an ack (tuser[0] = 0) or a flow reset (tuser[0] = 1) and yields exactly one
// response transaction with the updated Q16.16 window, slow-start state, batch
// loss flag and send permission. Items are handled one at a time: an ack or
// reset passes through evaluation and result hand-off before the next is accepted,
// and an ack that grows the window in congestion avoidance also waits for the
// window reciprocal, which comes from a bit-serial divider that
// yields one quotient bit per cycle. A finished result waits in an output
// register, so the next request is accepted while the response is still held.

module aimd_congestion_window_top
   import acw_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int TICK_BITS = TICK_BITS_DEF,
   parameter int FLOW_BITS = FLOW_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // seq_number[31:0], packet_flow[47:32], sent_tick[79:48],
   // received_tick[111:80], sent_count[143:112]
   input  logic [REQ_TDATA_BITS-1:0]  req_tdata,
   // action[0], first_of_batch[1]
   input  logic [REQ_TUSER_BITS-1:0]  req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // window_size[31:0], in_slow_start[32], loss_seen[33], may_send[34], zero pad
   output logic [RSP_TDATA_BITS-1:0]  rsp_tdata
);

   acw_cmd_type    cmd;
   acw_status_type status;

   acw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   acw_datapath #(
      .FRAC_BITS (FRAC_BITS),
      .TICK_BITS (TICK_BITS),
      .FLOW_BITS (FLOW_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

/* test/testbench.sv */
// Self-checking testbench for aimd_congestion_window_top: drives ack and flow-reset
// transactions, predicts every response and compares it field by field.
// Depends on acw_pkg and the aimd_congestion_window_top RTL.
`timescale 1ns / 1ps

module testbench;
   import acw_pkg::*;

   localparam int          CLK_HALF        = 4;
   localparam int          RESET_CYCLES    = 9;
   localparam int          STALL_LIMIT     = 4000;
   localparam int          DRAIN_CYCLES    = 30;
   localparam int          ITEMS_PER_PHASE = 450;
   localparam int          REPORT_LIMIT    = 10;
   localparam logic [63:0] WIN_ONE         = 64'd1 << FRAC_BITS_DEF;
   localparam logic [63:0] WIN_MAX         = 64'hFFFF_FFFF;
   localparam logic [31:0] SEQ_TOP         = 32'hFFFF_FFFF;
   localparam logic [15:0] FLOW_TOP        = 16'hFFFF;

   // One predicted response
   typedef struct packed {
      logic [31:0] window;
      logic        ss_on;
      logic        loss;
      logic        may_send;
   } cwnd_result_type;

   // Congestion window predictor plus the queue of responses still owed
   class cwnd_scoreboard;
      logic [63:0]     window;
      bit              ss_on;
      logic [31:0]     next_seq;
      logic [15:0]     flow_id;
      longint          loss_tick;
      longint          loss_rtt;
      bit              batch_loss;
      cwnd_result_type expected_windows[$];
      int              mismatches;

      function new();
         window     = WIN_ONE;
         ss_on      = 1'b1;
         next_seq   = '0;
         flow_id    = '0;
         loss_tick  = -1;
         loss_rtt   = -1;
         batch_loss = 1'b0;
         mismatches = 0;
      endfunction

      // Update the window state for one accepted request transaction
      function void apply_request(logic action, logic first, logic [31:0] seq,
                                  logic [15:0] flow, logic [31:0] t_sent,
                                  logic [31:0] t_recv, logic [31:0] sent_cnt);
         cwnd_result_type r;
         bit              loss;
         logic [32:0]     seq_next;
         longint          recv_s;
         longint          sent_s;
         if (action == ACTION_RESET) begin
            window     = WIN_ONE;
            ss_on      = 1'b1;
            flow_id    = flow_id + 16'd1;
            if (flow_id == '0) flow_id = 16'd1;
            next_seq   = sent_cnt;
         end else begin
            if (first) batch_loss = 1'b0;
            loss       = batch_loss || (seq > next_seq);
            batch_loss = loss;
            seq_next   = {1'b0, seq} + 33'd1;
            if (seq_next > {1'b0, next_seq})
               next_seq = seq_next[32] ? SEQ_TOP : seq_next[31:0];
            // only acks of the live flow move the window
            if (flow == flow_id) begin
               if (loss) begin
                  ss_on  = 1'b0;
                  recv_s = t_recv;
                  sent_s = t_sent;
                  // at most one halving per measured round trip
                  if (recv_s > loss_tick + loss_rtt) begin
                     window    = window >> 1;
                     loss_tick = recv_s;
                     loss_rtt  = recv_s - sent_s;
                  end
               end else if (ss_on) begin
                  window = window + WIN_ONE;
               end else begin
                  window = window + (WIN_ONE * WIN_ONE) / window;
               end
               if (window > WIN_MAX) window = WIN_MAX;
               if (window < WIN_ONE) window = WIN_ONE;
            end
         end
         r.window   = window[31:0];
         r.ss_on    = ss_on;
         r.loss     = batch_loss;
         r.may_send = (({32'b0, sent_cnt} << FRAC_BITS_DEF)
                       < (({32'b0, next_seq} << FRAC_BITS_DEF) + window));
         expected_windows.push_back(r);
      endfunction

      // Compare one response transaction with the oldest prediction
      function void match_response(logic [RSP_TDATA_BITS-1:0] d);
         cwnd_result_type got;
         cwnd_result_type want;
         got.window   = d[31:0];
         got.ss_on    = d[32];
         got.loss     = d[33];
         got.may_send = d[34];
         if (expected_windows.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: win %h ss %b loss %b send %b",
                        got.window, got.ss_on, got.loss, got.may_send);
            return;
         end
         want = expected_windows.pop_front();
         if (got.window !== want.window || got.ss_on !== want.ss_on ||
             got.loss !== want.loss || got.may_send !== want.may_send) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch %0t: win %h/%h ss %b/%b loss %b/%b send %b/%b (exp/act)",
                        $realtime, want.window, got.window, want.ss_on,
                        got.ss_on, want.loss, got.loss, want.may_send, got.may_send);
         end
      endfunction
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic [REQ_TUSER_BITS-1:0] req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;

   cwnd_scoreboard board = new();
   int          send_idle_pct = 37;
   int          recv_idle_pct = 54;
   int          idle_cycles   = 0;
   logic [31:0] tick_now      = 32'd1000;

   aimd_congestion_window_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Response side: check accepted transactions, then pick the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.match_response(rsp_tdata);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("aimd_congestion_window_top test failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Present one request, with a random gap first; valid stays up between back-to-back items
   task automatic drive_item(logic action, logic first, logic [31:0] seq, logic [15:0] flow,
                             logic [31:0] t_sent, logic [31:0] t_recv, logic [31:0] sent_cnt);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {first, action};
      req_tdata  <= {sent_cnt, t_recv, t_sent, flow, seq};
      do @(posedge clock); while (!req_tready);
      board.apply_request(action, first, seq, flow, t_sent, t_recv, sent_cnt);
   endtask

   // Mostly well-formed acks of the live flow, some resets, some noise
   task automatic random_item();
      int          pick;
      logic [31:0] seq;
      logic [31:0] rtt;
      logic [31:0] cnt;
      logic [15:0] flow;
      logic        first;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         drive_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                    16'($urandom), $urandom, $urandom, $urandom);
      end else if (pick < 11) begin
         drive_item(ACTION_RESET, 1'($urandom_range(0, 1)), $urandom, 16'($urandom),
                    $urandom, $urandom, board.next_seq + $urandom_range(0, 4));
      end else begin
         tick_now = tick_now + $urandom_range(1, 24);
         rtt      = $urandom_range(0, 60);
         pick     = $urandom_range(0, 99);
         if (pick < 80)      seq = board.next_seq;
         else if (pick < 90) seq = board.next_seq + $urandom_range(1, 4);
         else                seq = board.next_seq - $urandom_range(1, 3);
         flow  = ($urandom_range(0, 99) < 6) ? 16'(board.flow_id + $urandom_range(1, 3))
                                             : board.flow_id;
         first = ($urandom_range(0, 99) < 30);
         cnt   = board.next_seq + $urandom_range(0, int'(board.window[31:16]) + 2);
         drive_item(ACTION_ACK, first, seq, flow, tick_now - rtt, tick_now, cnt);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: in-order growth, gaps, round-trip timing, old flow, top values
      drive_item(ACTION_ACK,   1, 0, 0, 10, 20, 0);
      drive_item(ACTION_ACK,   0, 1, 0, 12, 25, 5);
      drive_item(ACTION_ACK,   0, 2, 0, 14, 28, 2);
      drive_item(ACTION_ACK,   0, 6, 0, 100, 130, 9);       // gap: slow start ends, halve
      drive_item(ACTION_ACK,   0, 7, 0, 110, 140, 9);       // loss sticks, same round trip
      drive_item(ACTION_ACK,   1, 8, 0, 150, 200, 9);       // new batch, reciprocal growth
      drive_item(ACTION_ACK,   1, 9, 0, 160, 210, 30);
      drive_item(ACTION_ACK,   1, 20, 0, 5000, 300, 30);    // loss with negative round trip
      drive_item(ACTION_ACK,   1, 30, 0, 0, 310, 30);       // halve below 1.0, clamps
      drive_item(ACTION_ACK,   1, 31, 16'h1234, 0, 320, 31); // ack of another flow
      drive_item(ACTION_ACK,   1, SEQ_TOP, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drive_item(ACTION_ACK,   1, SEQ_TOP, FLOW_TOP, 32'hFFFF_FFFF, 0, 0);
      drive_item(ACTION_ACK,   1, SEQ_TOP, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFE);
      drive_item(ACTION_RESET, 1, SEQ_TOP, FLOW_TOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
      drive_item(ACTION_ACK,   1, SEQ_TOP, 1, 5, 6, 32'hFFFF_FFFF);
      drive_item(ACTION_RESET, 0, 0, 0, 0, 0, 0);
      drive_item(ACTION_ACK,   1, 3, 2, 0, 0, 0);
      drive_item(ACTION_ACK,   1, 4, 2, 0, 32'h8000_0000, 4);
      drive_item(ACTION_ACK,   1, 5, 2, 32'h8000_0000, 32'h8000_0001, 7);
      drive_item(ACTION_ACK,   0, 0, 2, 1, 2, 0);
      drive_item(ACTION_ACK,   1, 6, 2, 32'h8000_0002, 32'h8000_0003, 32'h0000_0100);

      // Random phases: receiver-heavy idling, sender-heavy, then none
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 54 : 0;
         recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 37 : 0;
         repeat (ITEMS_PER_PHASE) random_item();
      end

      // One more flow reset, then acks of the new and the retired flow
      drive_item(ACTION_RESET, 0, 0, 0, 0, 0, 0);
      drive_item(ACTION_ACK, 1, 0, board.flow_id, 1, 2, 0);
      drive_item(ACTION_ACK, 1, 1, board.flow_id - 16'd1, 3, 4, 1);
      req_tvalid <= 1'b0;

      while (board.expected_windows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.expected_windows.size() == 0)
         $display("aimd_congestion_window_top test passed");
      else
         $display("aimd_congestion_window_top test failed");
      $finish;
   end

endmodule

/* sim.f */
hdl/acw_pkg.sv
hdl/acw_recip.sv
hdl/acw_datapath.sv
hdl/acw_ctrl.sv
hdl/aimd_congestion_window_top.sv
test/testbench.sv
